@@ rtl/core/urxfc_pkg.sv @@
// shared types, widths and codes for the uart receive fifo with flow control
// no dependencies

package urxfc_pkg;

	localparam int DEPTH_DEFAULT = 1024;

	localparam int CHAR_W    = 8;
	localparam int ERR_W     = 3;
	localparam int ENTRY_W   = CHAR_W + ERR_W;
	localparam int LEVEL_W   = 11;
	localparam int MODE_W    = 2;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	// flow modes
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SOFT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HARD = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESUME_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_LEVEL  = 2'd2;

	localparam logic [MODE_W-1:0]  FLOW_MODE_RESET    = MODE_NONE;
	localparam logic [LEVEL_W-1:0] RESUME_LEVEL_RESET = 11'd256;
	localparam logic [LEVEL_W-1:0] PAUSE_LEVEL_RESET  = 11'd768;

	localparam logic [CHAR_W-1:0] CH_XON  = 8'h11;
	localparam logic [CHAR_W-1:0] CH_XOFF = 8'h13;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [CHAR_W-1:0] rx_char;
		logic [ERR_W-1:0]  rx_error;
		logic              tx_ready;
		logic              sending_active;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  read_char;
		logic [ERR_W-1:0]   read_error;
		logic               read_valid;
		logic [LEVEL_W-1:0] stored_count;
		logic               dropped;
		logic               send_xon;
		logic               send_xoff;
		logic               rts_on;
		logic               transmit_paused;
		logic               transmitter_off;
		logic               transmitter_on;
	} out_item_t;

	typedef struct packed {
		logic [MODE_W-1:0]  flow_mode;
		logic [LEVEL_W-1:0] resume_level;
		logic [LEVEL_W-1:0] pause_level;
	} cfg_t;

	// control result of one word, held in the first pipeline stage
	typedef struct packed {
		logic               read_valid;
		logic [LEVEL_W-1:0] stored_count;
		logic               dropped;
		logic               send_xon;
		logic               send_xoff;
		logic               rts_on;
		logic               transmit_paused;
		logic               transmitter_off;
		logic               transmitter_on;
	} stage_t;

endpackage

@@ rtl/core/urxfc_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies

module urxfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/urxfc_ctrl.sv @@
// fifo pointers, fill level and flow control state, first pipeline stage
// depends on urxfc_pkg and urxfc_ram

module urxfc_ctrl import urxfc_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               load,
	input  in_item_t           item,
	input  cfg_t               cfg,
	output logic               valid_s1,
	output stage_t             data_s1,
	output logic [ENTRY_W-1:0] rd_entry
);

	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > LEVEL_W) ? CW : LEVEL_W;

	localparam logic [CW-1:0] FULL     = CW'(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	logic [IW-1:0] head_q, tail_q;
	logic [CW-1:0] fill_q;
	logic          rx_paused_q, peer_q, rts_q;

	logic [IW-1:0] head_nxt, tail_nxt;
	logic [CW-1:0] fill_nxt;
	logic          rx_paused_nxt, peer_nxt, rts_nxt;
	logic          fire, store, pop;
	stage_t        res;

	assign fire = in_valid && load;

	always_comb begin
		logic sw_flow, hard, clean, is_xoff, is_xon, pause_hit, resume_hit;
		logic [CW-1:0] fill_inc, fill_dec;
		sw_flow  = (cfg.flow_mode == MODE_SOFT);
		hard     = (cfg.flow_mode == MODE_HARD);
		clean    = (item.rx_error == '0);
		fill_inc = fill_q + CW'(1);
		fill_dec = fill_q - CW'(1);

		is_xoff       = 1'b0;
		is_xon        = 1'b0;
		pause_hit     = 1'b0;
		resume_hit    = 1'b0;
		head_nxt      = head_q;
		tail_nxt      = tail_q;
		fill_nxt      = fill_q;
		rx_paused_nxt = rx_paused_q;
		peer_nxt      = peer_q;
		rts_nxt       = rts_q;
		store         = 1'b0;
		pop           = 1'b0;
		res           = '0;

		unique case (item.operation)
			OP_RECEIVE: begin
				is_xoff = sw_flow && clean && (item.rx_char == CH_XOFF);
				is_xon  = sw_flow && clean && (item.rx_char == CH_XON);
				if (is_xoff) begin
					peer_nxt            = 1'b1;
					res.transmitter_off = item.sending_active;
				end else if (is_xon) begin
					peer_nxt           = 1'b0;
					res.transmitter_on = item.sending_active;
				end else if (fill_q != FULL) begin
					store     = 1'b1;
					tail_nxt  = (tail_q == LAST_IDX) ? '0 : tail_q + IW'(1);
					fill_nxt  = fill_inc;
					pause_hit = !rx_paused_q &&
						(CMPW'(fill_inc) > CMPW'(cfg.pause_level));
					if (pause_hit && sw_flow && item.tx_ready) begin
						res.send_xoff = 1'b1;
						rx_paused_nxt = 1'b1;
					end else if (pause_hit && hard) begin
						rts_nxt       = 1'b0;
						rx_paused_nxt = 1'b1;
					end
				end else begin
					res.dropped = 1'b1;
				end
			end
			OP_READ: begin
				if (fill_q != '0) begin
					pop            = 1'b1;
					res.read_valid = 1'b1;
					head_nxt       = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
					fill_nxt       = fill_dec;
					resume_hit     = rx_paused_q &&
						(CMPW'(fill_dec) < CMPW'(cfg.resume_level));
					if (resume_hit && sw_flow) begin
						res.send_xon  = 1'b1;
						rx_paused_nxt = 1'b0;
					end else if (resume_hit && hard) begin
						rts_nxt       = 1'b1;
						rx_paused_nxt = 1'b0;
					end
				end
			end
			OP_CLEAR: begin
				head_nxt = '0;
				tail_nxt = '0;
				fill_nxt = '0;
			end
			default: begin
				// unused code leaves the state alone
			end
		endcase

		res.stored_count    = LEVEL_W'(fill_nxt);
		res.rts_on          = rts_nxt;
		res.transmit_paused = peer_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			rx_paused_q <= 1'b0;
			peer_q      <= 1'b0;
			rts_q       <= 1'b1;
			valid_s1    <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				head_q      <= head_nxt;
				tail_q      <= tail_nxt;
				fill_q      <= fill_nxt;
				rx_paused_q <= rx_paused_nxt;
				peer_q      <= peer_nxt;
				rts_q       <= rts_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_s1 <= res;
		end
	end

	// read data lands alongside the stage register and holds until the next pop
	urxfc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (fire && store),
		.waddr(tail_q),
		.wdata({item.rx_error, item.rx_char}),
		.re   (fire && pop),
		.raddr(head_q),
		.rdata(rd_entry)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("fill level above depth");

	a_xoff_pauses: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.transmitter_off |=> peer_q)
		else $error("xoff did not set the transmit pause");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.dropped |=> fill_q == FULL)
		else $error("word dropped while buffer had room");

	a_pop_moves_head: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pop |=> head_q != $past(head_q))
		else $error("pop did not advance the head");

endmodule

@@ rtl/core/uart_rx_fifo_flow_control.sv @@
// uart receive fifo with xon/xoff and rts flow control, top level
// results pass the state and stage register, then the output register
// one word per cycle unless out_ready stalls; stage takes a word while a result waits
// reset clears pointers, fill level, pause flags, raises rts, loads level defaults
// ring contents are not cleared: only entries written since reset or clear are read
// depends on urxfc_pkg, urxfc_ctrl, urxfc_ram

module uart_rx_fifo_flow_control import urxfc_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [LEVEL_W-1:0]   wr_data
);

	cfg_t               cfg_q;
	logic               valid_s1, s1_adv;
	stage_t             data_s1;
	logic [ENTRY_W-1:0] rd_entry;
	logic               out_valid_q;
	out_item_t          out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flow_mode    <= FLOW_MODE_RESET;
			cfg_q.resume_level <= RESUME_LEVEL_RESET;
			cfg_q.pause_level  <= PAUSE_LEVEL_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FLOW_MODE:    cfg_q.flow_mode    <= wr_data[MODE_W-1:0];
				REG_RESUME_LEVEL: cfg_q.resume_level <= wr_data;
				REG_PAUSE_LEVEL:  cfg_q.pause_level  <= wr_data;
				default: begin
					// no register at this index
				end
			endcase
		end
	end

	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_adv;

	urxfc_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.load    (in_ready),
		.item    (in_data),
		.cfg     (cfg_q),
		.valid_s1(valid_s1),
		.data_s1 (data_s1),
		.rd_entry(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			out_data_q.read_char       <= data_s1.read_valid ? rd_entry[CHAR_W-1:0] : '0;
			out_data_q.read_error      <= data_s1.read_valid ?
				rd_entry[ENTRY_W-1:CHAR_W] : '0;
			out_data_q.read_valid      <= data_s1.read_valid;
			out_data_q.stored_count    <= data_s1.stored_count;
			out_data_q.dropped         <= data_s1.dropped;
			out_data_q.send_xon        <= data_s1.send_xon;
			out_data_q.send_xoff       <= data_s1.send_xoff;
			out_data_q.rts_on          <= data_s1.rts_on;
			out_data_q.transmit_paused <= data_s1.transmit_paused;
			out_data_q.transmitter_off <= data_s1.transmitter_off;
			out_data_q.transmitter_on  <= data_s1.transmitter_on;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_pulses_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({out_data_q.dropped, out_data_q.send_xon,
			out_data_q.send_xoff, out_data_q.transmitter_on,
			out_data_q.transmitter_off}))
		else $error("more than one flow pulse in a word");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(data_s1))
		else $error("stalled stage word lost");

endmodule

@@ test/urxfc_checker.sv @@
`timescale 1ns / 100ps
// checker for uart_rx_fifo_flow_control: keeps its own ring, pointers and flow flags,
// predicts one result word per accepted word and compares field by field
// depends on urxfc_pkg

module urxfc_checker import urxfc_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [LEVEL_W-1:0]   wr_data,
	output int                   fail_count,
	output int                   words_in_flight
);

	logic [ENTRY_W-1:0] ring [DEPTH];
	int unsigned        head;
	int unsigned        tail;
	int unsigned        fill;
	cfg_t               cfg;
	logic               rx_held;
	logic               peer_held;
	logic               rts;
	out_item_t          due_results [$];

	function automatic out_item_t uart_rx_outcome(input in_item_t w);
		out_item_t          r;
		logic [ENTRY_W-1:0] e;
		logic               plain;
		r = '0;
		// flow characters only count with software flow and a clean receive
		plain = (cfg.flow_mode != MODE_SOFT) || (w.rx_error != '0);
		case (w.operation)
			OP_RECEIVE: begin
				if (!plain && w.rx_char == CH_XOFF) begin
					peer_held = 1'b1;
					r.transmitter_off = w.sending_active;
				end else if (!plain && w.rx_char == CH_XON) begin
					peer_held = 1'b0;
					r.transmitter_on = w.sending_active;
				end else if (fill < DEPTH) begin
					ring[tail] = {w.rx_error, w.rx_char};
					tail = (tail + 1) % DEPTH;
					fill++;
					if (!rx_held && fill > cfg.pause_level) begin
						if (cfg.flow_mode == MODE_SOFT) begin
							// xoff waits for the transmitter, later receives retry
							if (w.tx_ready) begin
								r.send_xoff = 1'b1;
								rx_held = 1'b1;
							end
						end else if (cfg.flow_mode == MODE_HARD) begin
							rts = 1'b0;
							rx_held = 1'b1;
						end
					end
				end else begin
					r.dropped = 1'b1;
				end
			end
			OP_READ: begin
				if (fill != 0) begin
					e = ring[head];
					r.read_char = e[CHAR_W-1:0];
					r.read_error = e[ENTRY_W-1:CHAR_W];
					r.read_valid = 1'b1;
					head = (head + 1) % DEPTH;
					fill--;
					if (rx_held && fill < cfg.resume_level) begin
						if (cfg.flow_mode == MODE_SOFT) begin
							r.send_xon = 1'b1;
							rx_held = 1'b0;
						end else if (cfg.flow_mode == MODE_HARD) begin
							rts = 1'b1;
							rx_held = 1'b0;
						end
					end
				end
			end
			OP_CLEAR: begin
				// pause flags and rts are kept
				head = 0;
				tail = 0;
				fill = 0;
			end
			default: ;
		endcase
		r.stored_count = fill[LEVEL_W-1:0];
		r.rts_on = rts;
		r.transmit_paused = peer_held;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [LEVEL_W-1:0] want,
			input logic [LEVEL_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			head = 0;
			tail = 0;
			fill = 0;
			cfg.flow_mode = FLOW_MODE_RESET;
			cfg.resume_level = RESUME_LEVEL_RESET;
			cfg.pause_level = PAUSE_LEVEL_RESET;
			rx_held = 1'b0;
			peer_held = 1'b0;
			rts = 1'b1;
			due_results.delete();
			fail_count = 0;
			words_in_flight <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_FLOW_MODE:    cfg.flow_mode = wr_data[MODE_W-1:0];
					REG_RESUME_LEVEL: cfg.resume_level = wr_data;
					REG_PAUSE_LEVEL:  cfg.pause_level = wr_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result word with no word outstanding");
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("read_char", LEVEL_W'(want.read_char),
						LEVEL_W'(out_data.read_char));
					check_field("read_error", LEVEL_W'(want.read_error),
						LEVEL_W'(out_data.read_error));
					check_field("read_valid", LEVEL_W'(want.read_valid),
						LEVEL_W'(out_data.read_valid));
					check_field("stored_count", want.stored_count, out_data.stored_count);
					check_field("dropped", LEVEL_W'(want.dropped),
						LEVEL_W'(out_data.dropped));
					check_field("send_xon", LEVEL_W'(want.send_xon),
						LEVEL_W'(out_data.send_xon));
					check_field("send_xoff", LEVEL_W'(want.send_xoff),
						LEVEL_W'(out_data.send_xoff));
					check_field("rts_on", LEVEL_W'(want.rts_on),
						LEVEL_W'(out_data.rts_on));
					check_field("transmit_paused", LEVEL_W'(want.transmit_paused),
						LEVEL_W'(out_data.transmit_paused));
					check_field("transmitter_off", LEVEL_W'(want.transmitter_off),
						LEVEL_W'(out_data.transmitter_off));
					check_field("transmitter_on", LEVEL_W'(want.transmitter_on),
						LEVEL_W'(out_data.transmitter_on));
				end
			end
			if (in_valid && in_ready)
				due_results.push_back(uart_rx_outcome(in_data));
			words_in_flight <= due_results.size();
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// testbench top for uart_rx_fifo_flow_control: directed and random words, level settings
// and bursty handshakes; depends on urxfc_pkg, urxfc_checker and the rtl

module tb import urxfc_pkg::*; ();

	localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = REG_FLOW_MODE;
	logic [LEVEL_W-1:0]   wr_data = '0;
	int                   fail_count;
	int                   words_in_flight;
	int                   burst_left = 0;
	int                   stall_request = 0;

	always #1 clk = ~clk;

	uart_rx_fifo_flow_control u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	urxfc_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.fail_count      (fail_count),
		.words_in_flight (words_in_flight)
	);

	initial begin
		#2000000;
		$display("FAIL uart_rx_fifo_flow_control");
		$finish;
	end

	function automatic in_item_t word_of(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input logic [ERR_W-1:0] err, input logic txr, input logic busy);
		in_item_t w;
		w.operation = op;
		w.rx_char = ch;
		w.rx_error = err;
		w.tx_ready = txr;
		w.sending_active = busy;
		return w;
	endfunction

	function automatic in_item_t random_word(input int recv_pct, input int read_pct);
		in_item_t w;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < recv_pct)
			w.operation = OP_RECEIVE;
		else if (pick < recv_pct + read_pct)
			w.operation = OP_READ;
		else if (pick < 98)
			w.operation = OP_CLEAR;
		else
			w.operation = OP_UNUSED;
		// lean on the flow characters so the pause flag moves often
		case ($urandom_range(0, 7))
			0:       w.rx_char = CH_XON;
			1:       w.rx_char = CH_XOFF;
			default: w.rx_char = CHAR_W'($urandom_range(0, 255));
		endcase
		w.rx_error = ($urandom_range(0, 1) != 0) ? ERR_W'($urandom_range(0, 7)) : '0;
		w.tx_ready = ($urandom_range(0, 3) != 0);
		w.sending_active = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// offer one word in bursts with random gaps, return at the accepting edge
	task automatic offer_word(input in_item_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_in_flight != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_levels(input logic [MODE_W-1:0] mode, input logic [LEVEL_W-1:0] resume,
			input logic [LEVEL_W-1:0] pause);
		wr_en <= 1'b1;
		wr_index <= REG_FLOW_MODE;
		wr_data <= LEVEL_W'(mode);
		@(posedge clk);
		wr_index <= REG_RESUME_LEVEL;
		wr_data <= resume;
		@(posedge clk);
		wr_index <= REG_PAUSE_LEVEL;
		wr_data <= pause;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [LEVEL_W-1:0] resume,
			input logic [LEVEL_W-1:0] pause, input int words, input logic hold_off);
		settle();
		set_levels(mode, resume, pause);
		if (hold_off)
			stall_request <= stall_request + 1;
		repeat (words) offer_word(random_word(55, 40));
	endtask

	// receiver: runs of ready and stall, plus a long hold-off on request
	initial begin : receiver
		int   run_left;
		int   stall_seen;
		logic run_level;
		run_left = 0;
		stall_seen = 0;
		run_level = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_request != stall_seen) begin
				stall_seen = stall_request;
				out_ready <= 1'b0;
				repeat (80) @(posedge clk);
			end else begin
				if (run_left == 0) begin
					run_level = ($urandom_range(0, 3) != 0);
					run_left = (run_level && $urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 6);
				end
				out_ready <= run_level;
				run_left--;
			end
		end
	end

	initial begin : stimulus
		int fill_pause;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset levels, no flow control: xoff is plain data
		offer_word(word_of(OP_READ, 8'h00, 3'd0, 1'b1, 1'b0));
		offer_word(word_of(OP_RECEIVE, CH_XOFF, 3'd0, 1'b1, 1'b1));
		offer_word(word_of(OP_UNUSED, 8'hff, 3'd7, 1'b1, 1'b1));
		offer_word(word_of(OP_READ, 8'h00, 3'd0, 1'b0, 1'b0));
		settle();
		set_levels(MODE_SOFT, 11'd2, 11'd3);

		// peer flow characters with and without a send in progress
		offer_word(word_of(OP_RECEIVE, CH_XOFF, 3'd0, 1'b1, 1'b1));
		offer_word(word_of(OP_RECEIVE, CH_XON, 3'd0, 1'b1, 1'b1));
		offer_word(word_of(OP_RECEIVE, CH_XOFF, 3'd0, 1'b1, 1'b0));
		offer_word(word_of(OP_RECEIVE, CH_XON, 3'd0, 1'b1, 1'b0));
		// errored xoff is stored, then fill up to the pause level
		offer_word(word_of(OP_RECEIVE, CH_XOFF, 3'd4, 1'b1, 1'b0));
		offer_word(word_of(OP_RECEIVE, 8'hff, 3'd7, 1'b1, 1'b1));
		offer_word(word_of(OP_RECEIVE, 8'h00, 3'd0, 1'b1, 1'b0));
		// transmitter busy: no xoff yet
		offer_word(word_of(OP_RECEIVE, 8'h55, 3'd1, 1'b0, 1'b0));
		offer_word(word_of(OP_RECEIVE, 8'haa, 3'd2, 1'b1, 1'b1));
		offer_word(word_of(OP_RECEIVE, 8'h80, 3'd0, 1'b1, 1'b0));
		repeat (7) offer_word(word_of(OP_READ, 8'h00, 3'd0, 1'b1, 1'b0));
		offer_word(word_of(OP_RECEIVE, 8'h01, 3'd0, 1'b1, 1'b0));
		offer_word(word_of(OP_CLEAR, 8'h00, 3'd0, 1'b1, 1'b0));
		offer_word(word_of(OP_READ, 8'h00, 3'd0, 1'b1, 1'b0));

		run_phase(MODE_SOFT, 11'd4, 11'd6, 45, 1'b0);
		run_phase(MODE_HARD, 11'd0, 11'd0, 45, 1'b1);
		run_phase(MODE_UNUSED, 11'd5, 11'd5, 45, 1'b0);
		run_phase(MODE_NONE, 11'd3, 11'd3, 45, 1'b0);
		run_phase(MODE_SOFT, 11'd2047, 11'd2, 45, 1'b0);
		run_phase(MODE_HARD, 11'd9, 11'd12, 45, 1'b0);
		run_phase(MODE_SOFT, 11'd1024, 11'd2047, 45, 1'b0);

		// fill the ring to the top and beyond so words are dropped
		settle();
		fill_pause = $urandom_range(0, 1023);
		set_levels(MODE_HARD, 11'd1024, LEVEL_W'(fill_pause));
		stall_request <= stall_request + 1;
		offer_word(word_of(OP_CLEAR, 8'h00, 3'd0, 1'b1, 1'b0));
		repeat (1030) offer_word(random_word(100, 0));
		repeat (12) offer_word(random_word(30, 70));

		settle();
		repeat (6) @(posedge clk);
		if (fail_count == 0)
			$display("PASS uart_rx_fifo_flow_control");
		else
			$display("FAIL uart_rx_fifo_flow_control");
		$finish;
	end

endmodule
